[src/dcp_pkg.sv]
// Shared types and constants for the staircase counter.
`default_nettype none
package dcp_pkg;

   localparam int MaxN      = 127;
   localparam int CountBits = 32;
   localparam int BlockBits = 7;
   localparam int Depth     = MaxN + 1;
   localparam int AddrBits  = $clog2(Depth);

   typedef logic [AddrBits-1:0]  addr_type;
   typedef logic [CountBits-1:0] count_type;
   typedef logic [BlockBits-1:0] block_type;

   // One table entry: saturating count plus sticky overflow bit.
   typedef struct packed {
      logic      ovf;
      count_type count;
   } entry_type;

   // Table port control issued by the sequencer each cycle.
   typedef struct packed {
      logic     rd_en;
      addr_type rd_a;
      addr_type rd_b;
      logic     wr_en;
      addr_type wr_addr;
      logic     wr_sum;   // 1: write adder result, 0: write clear value
      logic     wr_one;   // clear value is one (entry zero) when set
   } mem_ctl_type;

endpackage
`default_nettype wire

[src/distinct_partition_counter.sv]
// Operation, for n >= 2: a clear sweep of entries 0..n, one pass per part size
//   k = 1..n-1 with a gap state after each, a final read of entry n, and a load
//   into the result register once it is free; for n < 2 the passes are skipped.
// Throughput: one item at a time, taken only while the sequencer is idle; the shared
//   saturating adder and single table write port allow one update per cycle in a pass.
// Reset: synchronous, active high; clears the sequencer and the result valid.
`default_nettype none
module distinct_partition_counter (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [6:0] block_count, [7] zero
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] staircase_count
   output logic [0:0]       rsp_tuser    // [0] saturated
);

   logic                 idle;
   logic                 load;
   logic                 start;
   logic                 out_free;
   dcp_pkg::mem_ctl_type ctl;
   dcp_pkg::entry_type   rd_a_data;
   dcp_pkg::entry_type   rd_b_data;
   dcp_pkg::entry_type   sum;
   dcp_pkg::entry_type   wr_data;

   logic                 rsp_valid_ff, rsp_valid_in;
   dcp_pkg::count_type   count_ff, count_in;
   logic                 sat_ff, sat_in;

   // Take a new transaction only while the sequencer sits idle.
   assign req_tready = idle;
   assign start      = req_tvalid & idle;

   // The result register frees up when empty or when its transaction leaves.
   assign out_free   = !rsp_valid_ff || rsp_tready;

   dcp_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .block    (req_tdata[dcp_pkg::BlockBits-1:0]),
      .out_free (out_free),
      .idle     (idle),
      .load     (load),
      .ctl      (ctl)
   );

   // Update uses t[s] + t[s-k]; clear writes one at entry zero, else zero.
   dcp_sat_add u_add (
      .a   (rd_a_data),
      .b   (rd_b_data),
      .sum (sum)
   );

   always_comb begin
      if (ctl.wr_sum) begin
         wr_data = sum;
      end else begin
         wr_data.ovf   = 1'b0;
         wr_data.count = dcp_pkg::count_type'(ctl.wr_one);
      end
   end

   dcp_table u_table (
      .clock     (clock),
      .ctl       (ctl),
      .wr_data   (wr_data),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   // Result register: load the final entry, hold until taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      count_in     = count_ff;
      sat_in       = sat_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         count_in     = rd_a_data.count;
         sat_in       = rd_a_data.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff <= count_in;
      sat_ff   <= sat_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = count_ff;
   assign rsp_tuser[0] = sat_ff;

endmodule
`default_nettype wire

[src/dcp_table.sv]
// Count table: one write port, two registered read ports.
`default_nettype none
module dcp_table (
   input  wire logic                clock,
   input  wire dcp_pkg::mem_ctl_type ctl,
   input  wire dcp_pkg::entry_type  wr_data,
   output dcp_pkg::entry_type       rd_a_data,
   output dcp_pkg::entry_type       rd_b_data
);

   dcp_pkg::entry_type entry_ff [dcp_pkg::Depth];
   dcp_pkg::entry_type rd_a_ff;
   dcp_pkg::entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         entry_ff[ctl.wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_a_ff <= entry_ff[ctl.rd_a];
         rd_b_ff <= entry_ff[ctl.rd_b];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule
`default_nettype wire

[src/dcp_sat_add.sv]
// Shared saturating adder with sticky overflow.
`default_nettype none
module dcp_sat_add (
   input  wire dcp_pkg::entry_type a,
   input  wire dcp_pkg::entry_type b,
   output dcp_pkg::entry_type      sum
);

   logic [dcp_pkg::CountBits:0] raw;
   logic                        ovf;

   always_comb begin
      raw       = {1'b0, a.count} + {1'b0, b.count};
      ovf       = a.ovf | b.ovf | raw[dcp_pkg::CountBits];
      sum.ovf   = ovf;
      sum.count = ovf ? '1 : raw[dcp_pkg::CountBits-1:0];
   end

endmodule
`default_nettype wire

[src/dcp_seq.sv]
// Sequencer: clear sweep, one pass per part size, final read, load.
`default_nettype none
module dcp_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire dcp_pkg::block_type   block,
   input  wire logic                 out_free,
   output logic                      idle,
   output logic                      load,
   output dcp_pkg::mem_ctl_type      ctl
);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StClear = 3'd1;
   localparam logic [2:0] StPass  = 3'd2;
   localparam logic [2:0] StGap   = 3'd3;
   localparam logic [2:0] StFinal = 3'd4;
   localparam logic [2:0] StLoad  = 3'd5;

   logic [2:0]        state_ff, state_in;
   dcp_pkg::addr_type n_ff, n_in;
   dcp_pkg::addr_type k_ff, k_in;
   dcp_pkg::addr_type s_ff, s_in;
   logic              p_ff, p_in;
   dcp_pkg::addr_type p_addr_ff, p_addr_in;
   dcp_pkg::addr_type n_clamp;

   always_comb begin
      if (int'(block) > dcp_pkg::MaxN) begin
         n_clamp = dcp_pkg::addr_type'(dcp_pkg::MaxN);
      end else begin
         n_clamp = dcp_pkg::addr_type'(block);
      end
   end

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      s_in      = s_ff;
      p_in      = 1'b0;
      p_addr_in = s_ff;
      idle      = 1'b0;
      load      = 1'b0;

      ctl         = '0;
      ctl.rd_a    = s_ff;
      ctl.rd_b    = s_ff - k_ff;
      // Drain the read issued last cycle: sum lands on its sum index.
      ctl.wr_en   = p_ff;
      ctl.wr_addr = p_addr_ff;
      ctl.wr_sum  = 1'b1;

      unique case (state_ff)
         StIdle: begin
            idle = 1'b1;
            if (start) begin
               n_in     = n_clamp;
               s_in     = '0;
               state_in = StClear;
            end
         end
         StClear: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = s_ff;
            ctl.wr_sum  = 1'b0;
            ctl.wr_one  = (s_ff == '0);
            if (s_ff == n_ff) begin
               if (n_ff < dcp_pkg::addr_type'(2)) begin
                  state_in = StFinal;
               end else begin
                  k_in     = dcp_pkg::addr_type'(1);
                  s_in     = n_ff;
                  state_in = StPass;
               end
            end else begin
               s_in = s_ff + dcp_pkg::addr_type'(1);
            end
         end
         StPass: begin
            ctl.rd_en = 1'b1;
            p_in      = 1'b1;
            if (s_ff == k_ff) begin
               state_in = StGap;
            end else begin
               s_in = s_ff - dcp_pkg::addr_type'(1);
            end
         end
         StGap: begin
            // Last write of the pass retires here before the next read.
            if (k_ff == n_ff - dcp_pkg::addr_type'(1)) begin
               state_in = StFinal;
            end else begin
               k_in     = k_ff + dcp_pkg::addr_type'(1);
               s_in     = n_ff;
               state_in = StPass;
            end
         end
         StFinal: begin
            ctl.rd_en = 1'b1;
            ctl.rd_a  = n_ff;
            state_in  = StLoad;
         end
         StLoad: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         p_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         p_ff     <= p_in;
      end
      n_ff      <= n_in;
      k_ff      <= k_in;
      s_ff      <= s_in;
      p_addr_ff <= p_addr_in;
   end

endmodule
`default_nettype wire

[bench/distinct_partition_counter_test.sv]
// Self-checking testbench for the staircase counter: predicts every count and compares it.
module distinct_partition_counter_test;

   // One expected result, tagged with the block count that caused it.
   typedef struct {
      dcp_pkg::block_type blocks;
      dcp_pkg::count_type count;
      logic               sat;
   } staircase_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;    // [6:0] block_count, [7] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [31:0] staircase_count
   logic [0:0]  rsp_tuser;          // [0] saturated

   staircase_type expected_counts[$];

   int error_count    = 0;
   int items_sent     = 0;
   int counts_checked = 0;
   int largest_blocks = 0;
   int rsp_hold       = 0;
   int next_hold      = 0;
   bit no_idle        = 1'b0;       // set for stretches where neither side idles

   distinct_partition_counter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hang guard: the slowest legal run (every item at n = 127 with the longest
   // gaps on both sides) stays under this limit several times over.
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   // Count the staircases of one block count: clear the table, seed the empty
   // sum, then fold in one part size per pass, walking the sums downward so a
   // part is used at most once. Each entry saturates with a sticky overflow.
   function automatic staircase_type predict_staircases(input dcp_pkg::block_type blocks);
      longint unsigned limit;
      longint unsigned tally [0:dcp_pkg::MaxN];
      bit              overflow [0:dcp_pkg::MaxN];
      int              top;
      staircase_type   res;
      limit = ~64'd0 >> (64 - dcp_pkg::CountBits);
      // Clamp to the table size; a 7-bit count cannot exceed it here.
      top = (int'(blocks) > dcp_pkg::MaxN) ? dcp_pkg::MaxN : int'(blocks);
      for (int s = 0; s <= dcp_pkg::MaxN; s++) begin
         tally[s]    = 0;
         overflow[s] = 1'b0;
      end
      tally[0] = 1;
      for (int k = 1; k < top; k++) begin
         for (int s = top; s >= k; s--) begin
            if (overflow[s] || overflow[s-k] || tally[s] > limit - tally[s-k]) begin
               tally[s]    = limit;
               overflow[s] = 1'b1;
            end else begin
               tally[s] = tally[s] + tally[s-k];
            end
         end
      end
      res.blocks = blocks;
      res.count  = dcp_pkg::count_type'(tally[top]);
      res.sat    = overflow[top];
      return res;
   endfunction

   // Idle cycles for one transaction on either side.
   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 11);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Send one block count. Valid is left high after the transaction so that a
   // back-to-back item does not touch it; drop it only when a gap is drawn.
   task automatic send_blocks(input dcp_pkg::block_type blocks);
      int gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {1'b0, blocks};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_counts.push_back(predict_staircases(blocks));
      items_sent++;
      if (int'(blocks) > largest_blocks) largest_blocks = blocks;
   endtask

   // Drop valid and hold off until every expected count has come back.
   task automatic drain_counts();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_counts.size() != 0) @(posedge clock);
   endtask

   task automatic check_staircase();
      staircase_type want;
      if (expected_counts.size() == 0) begin
         report_mismatch($sformatf("count %0d with no transaction pending", rsp_tdata));
         return;
      end
      want = expected_counts.pop_front();
      counts_checked++;
      if (rsp_tdata !== want.count)
         report_mismatch($sformatf("n=%0d count %0d, predicted %0d",
                                   want.blocks, rsp_tdata, want.count));
      if (rsp_tuser[0] !== want.sat)
         report_mismatch($sformatf("n=%0d saturated %b, predicted %b",
                                   want.blocks, rsp_tuser[0], want.sat));
   endtask

   // Result side: compare on each transaction, then draw a stall that only
   // runs down while a result is on offer, so the wait lands on the handshake.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= draw_wait();
      end else if (rsp_tvalid && rsp_tready) begin
         check_staircase();
         next_hold = draw_wait();
         rsp_hold   <= next_hold;
         rsp_tready <= (next_hold == 0);
      end else if (rsp_tvalid && rsp_hold != 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= (rsp_hold == 1);
      end else if (rsp_hold == 0) begin
         rsp_tready <= 1'b1;
      end
   end

   // Empty staircase, single block, and the smallest counts with parts to add.
   task automatic test_special_cases();
      send_blocks(dcp_pkg::block_type'(0));
      send_blocks(dcp_pkg::block_type'(1));
      send_blocks(dcp_pkg::block_type'(2));
      send_blocks(dcp_pkg::block_type'(3));
      drain_counts();
   endtask

   // Largest sizes, alternating bit patterns and a walking one over bits 2 to 6.
   // The saturation path cannot trigger with a 32-bit count and n <= 127; the
   // predictor still carries it so a false flag is caught.
   task automatic test_field_extremes();
      send_blocks(dcp_pkg::block_type'(dcp_pkg::MaxN));
      send_blocks(dcp_pkg::block_type'(dcp_pkg::MaxN - 1));
      send_blocks(dcp_pkg::block_type'(7'b1010101));
      send_blocks(dcp_pkg::block_type'(7'b0101010));
      for (int b = 2; b < dcp_pkg::BlockBits; b++)
         send_blocks(dcp_pkg::block_type'(1 << b));
      send_blocks(dcp_pkg::block_type'(63));
      drain_counts();
   endtask

   // Back-to-back burst, full drain with the sender held off, then another burst.
   task automatic test_drain_pause();
      no_idle = 1'b1;
      repeat (4) send_blocks(dcp_pkg::block_type'($urandom_range(0, 20)));
      drain_counts();
      repeat (3) send_blocks(dcp_pkg::block_type'($urandom_range(0, 20)));
      no_idle = 1'b0;
      drain_counts();
   endtask

   // Mostly small sizes to keep the run short, with a tenth drawn large.
   task automatic test_random_counts(input int total);
      dcp_pkg::block_type blocks;
      for (int i = 0; i < total; i++) begin
         if (i % 12 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if (i == total / 2) drain_counts();
         if ($urandom_range(0, 9) == 0)
            blocks = dcp_pkg::block_type'($urandom_range(41, dcp_pkg::MaxN));
         else
            blocks = dcp_pkg::block_type'($urandom_range(0, 40));
         send_blocks(blocks);
      end
      no_idle = 1'b0;
      drain_counts();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_special_cases();
      test_field_extremes();
      test_drain_pause();
      test_random_counts(80);
      // Allow a full worst-case latency for any stray result.
      repeat (8500) @(posedge clock);
      if (expected_counts.size() != 0)
         report_mismatch($sformatf("%0d counts never returned", expected_counts.size()));
      $display("Covered %0d block counts (largest n = %0d), %0d results compared.",
               items_sent, largest_blocks, counts_checked);
      $display("Corners: empty and single block, walking ones, n = 127; random idle on both sides.");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
